// ===== rtl/core/rqs_pkg.sv =====
// Shared types, codes and constants of the retransmit queue scheduler.
`default_nettype none

package rqs_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 8;
    localparam int DEFAULT_TIME_BITS   = 32;

    localparam int ID_W    = 8;
    localparam int HANDLE_W = 8;
    localparam int RETRY_W = 8;
    localparam int IVAL_W  = 16;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [IVAL_W-1:0]  RESET_SILENCE   = 16'd100;
    localparam logic [IVAL_W-1:0]  RESET_RETRY     = 16'd500;
    localparam logic [IVAL_W-1:0]  RESET_TIMEOUT   = 16'd2000;
    localparam logic [RETRY_W-1:0] RESET_MIN_RETRY = 8'd3;

    localparam logic [RETRY_W-1:0] RETRY_MAX = 8'hFF;

    // Register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_SILENCE   = 2'd0;
    localparam logic [1:0] REG_RETRY     = 2'd1;
    localparam logic [1:0] REG_TIMEOUT   = 2'd2;
    localparam logic [1:0] REG_MIN_RETRY = 2'd3;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_ENQUEUE = 2'd1,
        OP_ACK     = 2'd2,
        OP_RECEIVE = 2'd3
    } rqs_op_t;

    typedef enum logic [1:0] {
        ACT_TRANSMIT = 2'd0,
        ACT_DROP     = 2'd1,
        ACT_REJECT   = 2'd2
    } rqs_action_t;

    typedef struct packed {
        rqs_op_t             opcode;
        logic [ID_W-1:0]     packet_id;
        logic [HANDLE_W-1:0] payload_handle;
    } rqs_in_t;

    typedef struct packed {
        rqs_action_t         action;
        logic [ID_W-1:0]     out_packet_id;
        logic [HANDLE_W-1:0] out_payload_handle;
        logic [RETRY_W-1:0]  attempts_done;
        logic                kept_for_retry;
    } rqs_out_t;

    typedef struct packed {
        logic [IVAL_W-1:0]  silence_interval_ms;
        logic [IVAL_W-1:0]  retry_interval_ms;
        logic [IVAL_W-1:0]  send_timeout_ms;
        logic [RETRY_W-1:0] min_retry_count;
    } rqs_cfg_t;

    typedef struct packed {
        logic load;
        logic time_inc;
        logic stamp_rx;
        logic enqueue;
        logic reject;
        logic match_load;
        logic scan_step;
        logic ack_remove;
        logic eval;
        logic drop_head;
        logic send_once;
        logic send_keep;
    } rqs_cmd_t;

    typedef struct packed {
        rqs_op_t op;
        logic    full;
        logic    empty;
        logic    silent_wait;
        logic    timed_out;
        logic    retry_wait;
        logic    head_id_zero;
        logic    scan_hit;
        logic    scan_any;
    } rqs_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/retransmit_queue_scheduler_top.sv =====
// Top level of the retransmit queue scheduler: register port, controller and datapath.
//
//  port group   direction  handshake                       word
//  command      in         start & !busy                   rqs_in_t
//  result       out        result_valid, one cycle          rqs_out_t
//  psel/...     in/out     APB write at psel&penable&pwrite configuration
//
// Enqueue and receive end after decode; a tick steps through time update, compare and service.
// Ack searches the queue one entry per cycle.
// A result comes out the cycle after the item finishes; the receiver cannot stall.
// Reset empties the queue and clears both timers; no clearing pass is needed.
`default_nettype none

module retransmit_queue_scheduler_top #(
    parameter int QUEUE_DEPTH = rqs_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int TIME_BITS   = rqs_pkg::DEFAULT_TIME_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire rqs_pkg::rqs_in_t                  command,
    output logic                                   result_valid,
    output rqs_pkg::rqs_out_t                      result,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rqs_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [rqs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rqs_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);
    import rqs_pkg::*;

    rqs_cfg_t    cfg_reg;
    rqs_cmd_t    cmd;
    rqs_status_t status;
    logic        cfg_write;
    logic [1:0]  reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.silence_interval_ms <= RESET_SILENCE;
            cfg_reg.retry_interval_ms   <= RESET_RETRY;
            cfg_reg.send_timeout_ms     <= RESET_TIMEOUT;
            cfg_reg.min_retry_count     <= RESET_MIN_RETRY;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_SILENCE:   cfg_reg.silence_interval_ms <= pwdata[IVAL_W-1:0];
                REG_RETRY:     cfg_reg.retry_interval_ms   <= pwdata[IVAL_W-1:0];
                REG_TIMEOUT:   cfg_reg.send_timeout_ms     <= pwdata[IVAL_W-1:0];
                REG_MIN_RETRY: cfg_reg.min_retry_count     <= pwdata[RETRY_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SILENCE:   prdata = APB_DATA_W'(cfg_reg.silence_interval_ms);
            REG_RETRY:     prdata = APB_DATA_W'(cfg_reg.retry_interval_ms);
            REG_TIMEOUT:   prdata = APB_DATA_W'(cfg_reg.send_timeout_ms);
            REG_MIN_RETRY: prdata = APB_DATA_W'(cfg_reg.min_retry_count);
            default:       prdata = '0;
        endcase
    end

    rqs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    rqs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (command),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/rqs_ctrl.sv =====
// Sequencing state machine of the retransmit queue scheduler.
`default_nettype none

module rqs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire rqs_pkg::rqs_status_t status,
    output rqs_pkg::rqs_cmd_t       cmd
);
    import rqs_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_DECODE  = 5'b00010,
        ST_EVAL    = 5'b00100,
        ST_SERVICE = 5'b01000,
        ST_SCAN    = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.op)
                    OP_TICK:
                    begin
                        cmd.time_inc = 1'b1;
                        state_next   = ST_EVAL;
                    end
                    OP_ENQUEUE:
                    begin
                        cmd.reject  = status.full;
                        cmd.enqueue = !status.full;
                        state_next  = ST_IDLE;
                    end
                    OP_ACK:
                    begin
                        cmd.match_load = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    OP_RECEIVE:
                    begin
                        cmd.stamp_rx = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_SERVICE;
            end
            ST_SERVICE:
            begin
                // Priority: silence, timeout drop, retry gap, transmit
                if (!status.empty && !status.silent_wait)
                begin
                    if (status.timed_out)
                    begin
                        cmd.drop_head = 1'b1;
                    end
                    else if (!status.retry_wait)
                    begin
                        cmd.send_once = status.head_id_zero;
                        cmd.send_keep = !status.head_id_zero;
                    end
                end
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (!status.scan_any)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.scan_hit)
                begin
                    cmd.ack_remove = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/rqs_datapath.sv =====
// Queue storage, timers, compare flags and result register of the scheduler.
`default_nettype none

module rqs_datapath #(
    parameter int QUEUE_DEPTH = rqs_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int TIME_BITS   = rqs_pkg::DEFAULT_TIME_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rqs_pkg::rqs_in_t   command,
    input  wire rqs_pkg::rqs_cfg_t  cfg,
    input  wire rqs_pkg::rqs_cmd_t  cmd,
    output rqs_pkg::rqs_status_t    status,
    output logic                    result_valid,
    output rqs_pkg::rqs_out_t       result
);
    import rqs_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    logic [ID_W-1:0]      id_reg       [QUEUE_DEPTH];
    logic [HANDLE_W-1:0]  handle_reg   [QUEUE_DEPTH];
    logic [RETRY_W-1:0]   retries_reg  [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] next_reg     [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] deadline_reg [QUEUE_DEPTH];

    logic [OCC_W-1:0]       occ_reg;
    logic [TIME_BITS-1:0]   time_reg;
    logic [TIME_BITS-1:0]   rx_time_reg;
    rqs_in_t                in_reg;
    logic [QUEUE_DEPTH-1:0] match_reg;
    logic [IDX_W-1:0]       scan_idx_reg;

    logic                 silent_wait_reg;
    logic                 timed_out_reg;
    logic                 retry_wait_reg;
    logic [TIME_BITS-1:0] sum_retry_reg;
    logic [TIME_BITS-1:0] sum_timeout_reg;

    logic                 result_valid_reg;
    logic                 result_valid_next;
    rqs_out_t             result_reg;
    rqs_out_t             result_next;

    logic                 remove_en;
    logic [IDX_W-1:0]     remove_pos;
    logic [TIME_BITS-1:0] elapsed;
    logic [RETRY_W-1:0]   retries_inc;

    assign remove_en  = cmd.drop_head | cmd.send_once | cmd.ack_remove;
    assign remove_pos = cmd.ack_remove ? scan_idx_reg : '0;
    assign elapsed    = time_reg - rx_time_reg;
    assign retries_inc = (retries_reg[0] == RETRY_MAX) ? RETRY_MAX
                                                       : retries_reg[0] + 1'b1;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg          <= '0;
            time_reg         <= '0;
            rx_time_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (cmd.time_inc)
            begin
                time_reg <= time_reg + 1'b1;
            end
            if (cmd.stamp_rx)
            begin
                rx_time_reg <= time_reg;
            end
            if (cmd.enqueue)
            begin
                occ_reg <= occ_reg + 1'b1;
            end
            else if (remove_en)
            begin
                occ_reg <= occ_reg - 1'b1;
            end
        end
    end

    // Input latch, ack search vector and compare flags
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= command;
        end
        if (cmd.match_load)
        begin
            scan_idx_reg <= '0;
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                match_reg[i] <= (OCC_W'(i) < occ_reg) && (id_reg[i] == in_reg.packet_id);
            end
        end
        else if (cmd.scan_step)
        begin
            // Walk the match vector one entry per cycle
            scan_idx_reg <= scan_idx_reg + 1'b1;
            match_reg    <= match_reg >> 1;
        end
        if (cmd.eval)
        begin
            silent_wait_reg <= elapsed < TIME_BITS'(cfg.silence_interval_ms);
            timed_out_reg   <= (deadline_reg[0] != '0) && (time_reg > deadline_reg[0])
                               && (retries_reg[0] >= cfg.min_retry_count);
            retry_wait_reg  <= (next_reg[0] != '0) && (time_reg < next_reg[0]);
            sum_retry_reg   <= time_reg + TIME_BITS'(cfg.retry_interval_ms);
            sum_timeout_reg <= time_reg + TIME_BITS'(cfg.send_timeout_ms);
        end
    end

    // Queue storage: append at the tail, close gaps by shifting down
    always_ff @(posedge clk)
    begin
        if (cmd.enqueue)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (IDX_W'(i) == occ_reg[IDX_W-1:0])
                begin
                    id_reg[i]       <= in_reg.packet_id;
                    handle_reg[i]   <= in_reg.payload_handle;
                    retries_reg[i]  <= '0;
                    next_reg[i]     <= '0;
                    deadline_reg[i] <= '0;
                end
            end
        end
        else if (remove_en)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                if (IDX_W'(i) >= remove_pos)
                begin
                    id_reg[i]       <= id_reg[i+1];
                    handle_reg[i]   <= handle_reg[i+1];
                    retries_reg[i]  <= retries_reg[i+1];
                    next_reg[i]     <= next_reg[i+1];
                    deadline_reg[i] <= deadline_reg[i+1];
                end
            end
        end
        else if (cmd.send_keep)
        begin
            retries_reg[0] <= retries_inc;
            next_reg[0]    <= sum_retry_reg;
            if (deadline_reg[0] == '0)
            begin
                deadline_reg[0] <= sum_timeout_reg;
            end
        end
    end

    always_comb
    begin
        result_valid_next = cmd.reject | cmd.drop_head | cmd.send_once | cmd.send_keep;
        result_next.action             = ACT_TRANSMIT;
        result_next.out_packet_id      = id_reg[0];
        result_next.out_payload_handle = handle_reg[0];
        result_next.attempts_done      = retries_reg[0];
        result_next.kept_for_retry     = 1'b0;
        if (cmd.reject)
        begin
            result_next.action             = ACT_REJECT;
            result_next.out_packet_id      = in_reg.packet_id;
            result_next.out_payload_handle = in_reg.payload_handle;
            result_next.attempts_done      = '0;
        end
        else if (cmd.drop_head)
        begin
            result_next.action = ACT_DROP;
        end
        else if (cmd.send_keep)
        begin
            result_next.attempts_done  = retries_inc;
            result_next.kept_for_retry = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_valid_next)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign status.op           = in_reg.opcode;
    assign status.full         = (occ_reg >= OCC_W'(QUEUE_DEPTH));
    assign status.empty        = (occ_reg == '0);
    assign status.silent_wait  = silent_wait_reg;
    assign status.timed_out    = timed_out_reg;
    assign status.retry_wait   = retry_wait_reg;
    assign status.head_id_zero = (id_reg[0] == '0);
    assign status.scan_hit     = match_reg[0];
    assign status.scan_any     = |match_reg;

endmodule

`default_nettype wire

// ===== sim/tb_retransmit_queue_scheduler_top.sv =====
// Testbench for the retransmit queue scheduler: stimulus, register writes, result checks.
`default_nettype none

module tb_retransmit_queue_scheduler_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rqs_pkg::*;

    localparam int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
    localparam int TIME_BITS   = DEFAULT_TIME_BITS;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = QUEUE_DEPTH + 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    rqs_in_t command = '0;
    logic result_valid;
    rqs_out_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    // Scheduler mirror: queue contents, clock and settings
    logic [ID_W-1:0]      q_id       [QUEUE_DEPTH];
    logic [HANDLE_W-1:0]  q_handle   [QUEUE_DEPTH];
    logic [RETRY_W-1:0]   q_tries    [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] q_next     [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] q_deadline [QUEUE_DEPTH];
    int                   q_count;
    logic [TIME_BITS-1:0] now_ms;
    logic [TIME_BITS-1:0] last_rx_ms;
    rqs_cfg_t             cfg_model;

    rqs_in_t  command_backlog[$];
    rqs_out_t due_actions[$];
    int       errors = 0;
    int       cycle_count = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    rqs_out_t predicted;
    bit       has_action;
    rqs_out_t want;

    retransmit_queue_scheduler_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rqs_in_t make_item(input rqs_op_t op, input logic [ID_W-1:0] id,
                                          input logic [HANDLE_W-1:0] handle);
        rqs_in_t w;
        w.opcode = op;
        w.packet_id = id;
        w.payload_handle = handle;
        return w;
    endfunction

    // Append a word to the send backlog
    function automatic void queue_word(input rqs_in_t w);
        command_backlog = {command_backlog, w};
    endfunction

    // Take the oldest word off the send backlog
    function automatic rqs_in_t take_word();
        rqs_in_t w;
        w = command_backlog[0];
        command_backlog.delete(0);
        return w;
    endfunction

    // Close the gap left by a removed entry, keeping order
    function automatic void remove_entry(input int pos);
        for (int i = pos; i + 1 < q_count; i++)
        begin
            q_id[i]       = q_id[i + 1];
            q_handle[i]   = q_handle[i + 1];
            q_tries[i]    = q_tries[i + 1];
            q_next[i]     = q_next[i + 1];
            q_deadline[i] = q_deadline[i + 1];
        end
        q_count--;
    endfunction

    function automatic bit service_event(input rqs_in_t ev, output rqs_out_t act);
        logic [RETRY_W-1:0] tries;
        bit hit;
        bit found;
        act = '0;
        hit = 1'b0;
        found = 1'b0;
        case (ev.opcode)
            OP_TICK:
            begin
                now_ms = now_ms + 1'b1;
                if (q_count != 0 && (now_ms - last_rx_ms) >= cfg_model.silence_interval_ms)
                begin
                    tries = q_tries[0];
                    act.out_packet_id = q_id[0];
                    act.out_payload_handle = q_handle[0];
                    act.attempts_done = tries;
                    if (q_deadline[0] != 0 && now_ms > q_deadline[0] &&
                        tries >= cfg_model.min_retry_count)
                    begin
                        act.action = ACT_DROP;
                        remove_entry(0);
                        hit = 1'b1;
                    end
                    else if (q_next[0] == 0 || now_ms >= q_next[0])
                    begin
                        act.action = ACT_TRANSMIT;
                        // fire-and-forget ids leave after one send
                        if (q_id[0] == 0)
                            remove_entry(0);
                        else
                        begin
                            if (tries != RETRY_MAX)
                                tries++;
                            q_tries[0] = tries;
                            q_next[0] = now_ms + cfg_model.retry_interval_ms;
                            if (q_deadline[0] == 0)
                                q_deadline[0] = now_ms + cfg_model.send_timeout_ms;
                            act.attempts_done = tries;
                            act.kept_for_retry = 1'b1;
                        end
                        hit = 1'b1;
                    end
                end
            end
            OP_ENQUEUE:
            begin
                if (q_count >= QUEUE_DEPTH)
                begin
                    act.action = ACT_REJECT;
                    act.out_packet_id = ev.packet_id;
                    act.out_payload_handle = ev.payload_handle;
                    hit = 1'b1;
                end
                else
                begin
                    q_id[q_count]       = ev.packet_id;
                    q_handle[q_count]   = ev.payload_handle;
                    q_tries[q_count]    = '0;
                    q_next[q_count]     = '0;
                    q_deadline[q_count] = '0;
                    q_count++;
                end
            end
            OP_ACK:
            begin
                for (int i = 0; i < q_count; i++)
                begin
                    if (!found && q_id[i] == ev.packet_id)
                    begin
                        remove_entry(i);
                        found = 1'b1;
                    end
                end
            end
            OP_RECEIVE:
                last_rx_ms = now_ms;
            default:
                ;
        endcase
        return hit;
    endfunction

    task automatic write_register(input logic [1:0] index, input logic [APB_DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_SILENCE:   cfg_model.silence_interval_ms = value[IVAL_W-1:0];
            REG_RETRY:     cfg_model.retry_interval_ms = value[IVAL_W-1:0];
            REG_TIMEOUT:   cfg_model.send_timeout_ms = value[IVAL_W-1:0];
            REG_MIN_RETRY: cfg_model.min_retry_count = value[RETRY_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic write_config(input logic [IVAL_W-1:0] silence,
                                input logic [IVAL_W-1:0] retry,
                                input logic [IVAL_W-1:0] timeout,
                                input logic [RETRY_W-1:0] min_retry);
        write_register(REG_SILENCE, APB_DATA_W'(silence));
        write_register(REG_RETRY, APB_DATA_W'(retry));
        write_register(REG_TIMEOUT, APB_DATA_W'(timeout));
        write_register(REG_MIN_RETRY, APB_DATA_W'(min_retry));
    endtask

    // Hold until every word is sent and answered, then let an ack search run out
    task automatic settle();
        while (command_backlog.size() != 0 || start || due_actions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Sender: bursts of words with random gaps between them
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                has_action = service_event(command, predicted);
                if (has_action)
                    due_actions = {due_actions, predicted};
                if (burst_left > 0)
                    burst_left--;
            end
            if (!start || !busy)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
                if (gap_left > 0 || command_backlog.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    start <= 1'b0;
                end
                else
                begin
                    start <= 1'b1;
                    command <= take_word();
                end
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (due_actions.size() == 0)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: result with none due: act=%0d id=%0d handle=%0d ",
                             "tries=%0d kept=%0d",
                             $time, result.action, result.out_packet_id,
                             result.out_payload_handle, result.attempts_done,
                             result.kept_for_retry);
            end
            else
            begin
                want = due_actions[0];
                due_actions.delete(0);
                if (result.action !== want.action ||
                    result.out_packet_id !== want.out_packet_id ||
                    result.out_payload_handle !== want.out_payload_handle ||
                    result.attempts_done !== want.attempts_done ||
                    result.kept_for_retry !== want.kept_for_retry)
                begin
                    errors++;
                    if (errors <= 40)
                        $display("%0t: mismatch expected act=%0d id=%0d handle=%0d ",
                                 "tries=%0d kept=%0d, ",
                                 "got act=%0d id=%0d handle=%0d tries=%0d kept=%0d",
                                 $time, want.action, want.out_packet_id,
                                 want.out_payload_handle, want.attempts_done,
                                 want.kept_for_retry, result.action, result.out_packet_id,
                                 result.out_payload_handle, result.attempts_done,
                                 result.kept_for_retry);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_retransmit_queue_scheduler_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        int tick_weight;
        int r;
        int id;
        int held;
        rqs_op_t op;
        logic [IVAL_W-1:0] silence;
        logic [IVAL_W-1:0] retry;
        logic [IVAL_W-1:0] timeout;
        logic [RETRY_W-1:0] min_retry;

        q_count = 0;
        now_ms = '0;
        last_rx_ms = '0;
        cfg_model.silence_interval_ms = RESET_SILENCE;
        cfg_model.retry_interval_ms = RESET_RETRY;
        cfg_model.send_timeout_ms = RESET_TIMEOUT;
        cfg_model.min_retry_count = RESET_MIN_RETRY;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_id[i] = '0;
            q_handle[i] = '0;
            q_tries[i] = '0;
            q_next[i] = '0;
            q_deadline[i] = '0;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: empty-queue tick, enqueue, ticks still inside the quiet time, then an ack
        queue_word(make_item(OP_TICK, 8'd0, 8'd0));
        queue_word(make_item(OP_ENQUEUE, 8'd3, 8'd9));
        repeat (3) queue_word(make_item(OP_TICK, 8'd0, 8'd0));
        queue_word(make_item(OP_ACK, 8'd3, 8'd0));
        settle();

        // Directed: fill, overflow, ack cases, then send, retry and timeout drop
        write_config(16'd2, 16'd3, 16'd6, 8'd1);
        queue_word(make_item(OP_RECEIVE, 8'd0, 8'd0));
        queue_word(make_item(OP_ENQUEUE, 8'h00, 8'hFF));
        queue_word(make_item(OP_ENQUEUE, 8'hFF, 8'h00));
        queue_word(make_item(OP_ENQUEUE, 8'h00, 8'h11));
        queue_word(make_item(OP_ENQUEUE, 8'hAA, 8'h55));
        queue_word(make_item(OP_ENQUEUE, 8'h55, 8'hAA));
        queue_word(make_item(OP_ENQUEUE, 8'h01, 8'h80));
        queue_word(make_item(OP_ENQUEUE, 8'h80, 8'h01));
        queue_word(make_item(OP_ENQUEUE, 8'h7F, 8'hFE));
        queue_word(make_item(OP_ENQUEUE, 8'hFF, 8'hFF));
        queue_word(make_item(OP_ENQUEUE, 8'h00, 8'h00));
        queue_word(make_item(OP_ACK, 8'h37, 8'h00));
        queue_word(make_item(OP_ACK, 8'h00, 8'h00));
        queue_word(make_item(OP_ACK, 8'h55, 8'h00));
        repeat (12) queue_word(make_item(OP_TICK, 8'd0, 8'd0));
        settle();

        // Retry count saturation: one entry sent on every tick, never timing out
        write_config(16'd0, 16'd0, 16'hFFFF, 8'hFF);
        held = q_count;
        for (int k = 0; k < held; k++)
            queue_word(make_item(OP_ACK, q_id[k], 8'd0));
        queue_word(make_item(OP_ENQUEUE, 8'd1, 8'h5A));
        repeat (270) queue_word(make_item(OP_TICK, 8'd0, 8'd0));
        queue_word(make_item(OP_ACK, 8'd1, 8'd0));
        settle();

        for (int p = 0; p < 8; p++)
        begin
            if (p == 0)
                write_config('0, '0, '0, '0);
            else if (p == 1)
                write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
            else
            begin
                r = $urandom_range(0, 9);
                silence = (r == 0) ? 16'hFFFF : (r == 1) ? 16'd0 : 16'($urandom_range(0, 6));
                r = $urandom_range(0, 9);
                retry = (r == 0) ? 16'hFFFF : (r == 1) ? 16'd0 : 16'($urandom_range(0, 12));
                r = $urandom_range(0, 9);
                timeout = (r == 0) ? 16'($urandom_range(0, 65535)) :
                          (r == 1) ? 16'd0 : 16'($urandom_range(0, 40));
                r = $urandom_range(0, 9);
                min_retry = (r == 0) ? 8'hFF : 8'($urandom_range(0, 4));
                write_config(silence, retry, timeout, min_retry);
            end
            tick_weight = $urandom_range(40, 70);
            for (int k = 0; k < 60; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < tick_weight)
                    op = OP_TICK;
                else if (r < tick_weight + (100 - tick_weight) * 45 / 100)
                    op = OP_ENQUEUE;
                else if (r < tick_weight + (100 - tick_weight) * 80 / 100)
                    op = OP_ACK;
                else
                    op = OP_RECEIVE;
                // mostly a small id pool so acks find their entries
                id = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
                queue_word(make_item(op, 8'(id), 8'($urandom_range(0, 255))));
            end
            settle();
        end

        if (errors == 0 && due_actions.size() == 0)
            $display("tb_retransmit_queue_scheduler_top: done, clean");
        else
            $display("tb_retransmit_queue_scheduler_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
